### design/lzfd_pkg.sv
// Package for the LZF framed stream decompressor: payload types and constants.
package lzfd_pkg;

  localparam int unsigned WindowBytes = 8192;
  localparam int unsigned PtrW = $clog2(WindowBytes);
  localparam int unsigned Lane = 8;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadHeader = 3'd1;
  localparam logic [2:0] StOver      = 3'd2;
  localparam logic [2:0] StTrunc     = 3'd3;
  localparam logic [2:0] StBadRef    = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        end_of_frame;
    logic [2:0]  status;
    logic [31:0] total_length;
  } out_item_t;

endpackage

### design/lzfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lzfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/lzf_framed_stream_decompressor.sv
// LZF framed stream decompressor top level.
// Input channel: one framed byte per transfer (in_valid_i/in_ready_o), with
// frame_last marking the final byte of a frame. Output channel: results of up
// to 8 decoded bytes plus status (out_valid_o/out_ready_i).
// Header, size and control bytes make no result.
// Raw and literal bytes each make a one-byte result in the output register in the
// cycle after their transfer; the input waits for it to drain, so the next byte
// is taken only once that result has left.
// A back reference of N bytes reads the 8 KiB history RAM one byte per cycle,
// pausing each time its gathered bytes move to the output register (registered
// read, pipelined, last write forwarded), and emits results of up to 8 bytes;
// the input is held off until the reference is done.
// Each frame end produces an extra end transfer with the status and total.
// After an error, input bytes up to frame_last are taken and dropped.
// Reset clears all control state; the history RAM needs no clearing since a
// reference may only reach bytes decoded in the current frame.
// A stalled receiver holds the output register; the input is then accepted
// only while no result is pending.
module lzf_framed_stream_decompressor
  import lzfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t res_data_o
);

  typedef enum logic [2:0] {
    PhHeader, PhSize, PhCtrl, PhLit, PhExt, PhOff, PhRaw
  } phase_e;

  typedef enum logic [1:0] {
    SIn, SCopy, SFlush, SEnd
  } mode_e;

  phase_e      phase_q;
  mode_e       mode_q;
  logic        disc_q, last_q;
  logic [2:0]  sbytes_q, st_q;
  logic [31:0] exp_q, prod_q;
  logic [5:0]  lit_q;
  logic [8:0]  clen_q;
  logic [4:0]  ohi_q;
  logic [PtrW-1:0] wp_q, rp_q;
  logic [8:0]  cleft_q;
  logic        rd_q;
  logic [63:0] acc_q;
  logic [3:0]  acnt_q;
  logic        ov_q;
  out_item_t   od_q;
  logic [7:0]  rdata;
  logic        fwd_q;
  logic [7:0]  fwd_data_q;
  logic [7:0]  cdata;

  logic        we;
  logic [PtrW-1:0] waddr;
  logic [7:0]  wdata;

  wire out_free = !ov_q || out_ready_i;
  wire accept = in_valid_i && in_ready_o;
  wire ov_set = (accept && !disc_q && (phase_q == PhRaw || phase_q == PhLit)) ||
                ((mode_q == SFlush || mode_q == SEnd) && out_free);
  assign in_ready_o = (mode_q == SIn) && !ov_q;
  assign out_valid_o = ov_q;
  assign res_data_o = od_q;
  assign cdata = fwd_q ? fwd_data_q : rdata;

  lzfd_ram #(.Width(8), .Depth(WindowBytes)) u_hist (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(rp_q), .rdata_o(rdata)
  );

  wire [7:0]  b = in_data_i.in_byte;
  wire        last = in_data_i.frame_last;
  wire [13:0] ref_dist = {ohi_q, b} + 14'd1;
  wire [32:0] ccnt = {24'd0, clen_q} + 33'd2;
  wire [32:0] lcnt = {25'd0, b} + 33'd1;

  always_comb begin
    we = 1'b0;
    waddr = wp_q;
    wdata = b;
    if (mode_q == SIn && accept && !disc_q && phase_q == PhLit) we = 1'b1;
    if (mode_q == SCopy && rd_q) begin
      we = 1'b1;
      wdata = cdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; mode_q <= SIn; disc_q <= 1'b0; last_q <= 1'b0;
      sbytes_q <= '0; st_q <= StOk; exp_q <= '0; prod_q <= '0; lit_q <= '0;
      clen_q <= '0; ohi_q <= '0; wp_q <= '0; rp_q <= '0; cleft_q <= '0;
      rd_q <= 1'b0; acc_q <= '0; acnt_q <= '0; ov_q <= 1'b0; od_q <= '0;
      fwd_q <= 1'b0; fwd_data_q <= '0;
    end else begin
      if (ov_set) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (we) wp_q <= wp_q + PtrW'(1);
      // a read of the entry written in the same cycle returns the old byte
      fwd_q <= we && (waddr == rp_q);
      fwd_data_q <= wdata;
      unique case (mode_q)
        SIn: if (accept) begin
          if (disc_q) begin
            if (last) disc_q <= 1'b0;
          end else begin
            logic [2:0] st;
            logic fin;
            phase_e nph;
            st = StOk; fin = 1'b0; nph = phase_q;
            unique case (phase_q)
              PhHeader: begin
                prod_q <= '0; exp_q <= '0; clen_q <= '0; ohi_q <= '0;
                acc_q <= '0; acnt_q <= '0;
                if (b[7:4] > 4'd1 || !(b[3:0] == 4'd1 || b[3:0] == 4'd2 ||
                    b[3:0] == 4'd4)) st = StBadHeader;
                else if (b[4]) begin
                  sbytes_q <= b[2:0]; nph = PhSize;
                end else nph = PhRaw;
              end
              PhSize: begin
                exp_q <= {exp_q[23:0], b};
                sbytes_q <= sbytes_q - 3'd1;
                if (sbytes_q == 3'd1) begin
                  if (last) st = StTrunc; else nph = PhCtrl;
                end
              end
              PhRaw: begin
                od_q <= '{out_bytes: {56'd0, b}, byte_count: 4'd1, end_of_frame: 1'b0,
                          status: StOk,
                          total_length: (prod_q == '1) ? prod_q : prod_q + 32'd1};
                if (prod_q != '1) prod_q <= prod_q + 32'd1;
              end
              PhCtrl: begin
                if (b < 8'd32) begin
                  if ({1'b0, prod_q} + lcnt > {1'b0, exp_q}) st = StOver;
                  else begin
                    lit_q <= 6'(lcnt); nph = PhLit;
                  end
                end else begin
                  clen_q <= {6'd0, b[7:5]}; ohi_q <= b[4:0];
                  nph = (b[7:5] == 3'd7) ? PhExt : PhOff;
                end
              end
              PhLit: begin
                od_q <= '{out_bytes: {56'd0, b}, byte_count: 4'd1, end_of_frame: 1'b0,
                          status: StOk, total_length: prod_q + 32'd1};
                prod_q <= prod_q + 32'd1;
                lit_q <= lit_q - 6'd1;
                if (lit_q == 6'd1) nph = PhCtrl;
              end
              PhExt: begin
                clen_q <= clen_q + {1'b0, b}; nph = PhOff;
              end
              PhOff: begin
                nph = PhCtrl;
                if ({1'b0, prod_q} + ccnt > {1'b0, exp_q}) st = StOver;
                else if ({18'd0, ref_dist} > prod_q) st = StBadRef;
                else begin
                  rp_q <= wp_q - PtrW'(ref_dist);
                  cleft_q <= 9'(ccnt); rd_q <= 1'b0;
                  acc_q <= '0; acnt_q <= '0;
                end
              end
              default: nph = PhHeader;
            endcase
            if (st == StOk && last) begin
              fin = 1'b1;
              if (nph != PhCtrl && nph != PhRaw) st = StTrunc;
            end
            if (st != StOk) fin = 1'b1;
            st_q <= st;
            last_q <= last;
            phase_q <= fin ? PhHeader : nph;
            if (phase_q == PhOff && st == StOk) mode_q <= SCopy;
            else if (fin) mode_q <= SEnd;
          end
        end
        SCopy: begin
          // read pipeline: issue reads while cleft_q>0 and the result is not about to fill, write on return
          if (rd_q) begin
            acc_q <= acc_q | ({56'd0, cdata} << {acnt_q[2:0], 3'b000});
            acnt_q <= acnt_q + 4'd1;
            prod_q <= prod_q + 32'd1;
          end
          if (cleft_q != '0 && !(rd_q && acnt_q == 4'd7)) begin
            rp_q <= rp_q + PtrW'(1); cleft_q <= cleft_q - 9'd1; rd_q <= 1'b1;
          end else rd_q <= 1'b0;
          if (rd_q && (acnt_q == 4'd7 || (cleft_q == '0))) begin
            mode_q <= SFlush;
          end
        end
        SFlush: if (out_free) begin
          od_q <= '{out_bytes: acc_q, byte_count: acnt_q, end_of_frame: 1'b0,
                    status: StOk, total_length: prod_q};
          acc_q <= '0; acnt_q <= '0;
          if (cleft_q != '0) mode_q <= SCopy;
          else if (last_q && phase_q == PhHeader) mode_q <= SEnd;
          else mode_q <= SIn;
        end
        SEnd: if (out_free) begin
          od_q <= '{out_bytes: 64'd0, byte_count: 4'd0, end_of_frame: 1'b1,
                    status: st_q, total_length: prod_q};
          disc_q <= !last_q;
          mode_q <= SIn;
        end
        default: mode_q <= SIn;
      endcase
    end
  end

endmodule
